[hw/rtl/tcw_pkg.sv]
// Shared constants and types of the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;
  localparam int MOVE_COUNT  = CELL_COUNT - SCREEN_COLS;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 2 * BYTE_W;
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Stream widths
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SETC  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  // Character codes and reset attribute
  localparam logic [BYTE_W-1:0] NEWLINE_CODE   = 8'd10;
  localparam logic [BYTE_W-1:0] SPACE_CODE     = 8'd32;
  localparam logic [BYTE_W-1:0] DFLT_ATTR_RST  = 8'd15;

  // Geometry as typed constants
  localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(SCREEN_COLS);
  localparam logic [ADDR_W-1:0] MOVE_LAST_A = ADDR_W'(MOVE_COUNT);
  localparam logic [ADDR_W-1:0] CELL_LAST_A = ADDR_W'(CELL_COUNT - 1);
  localparam logic [COL_W:0]    COLS_C      = (COL_W + 1)'(SCREEN_COLS);
  localparam logic [ROW_W:0]    ROWS_R      = (ROW_W + 1)'(SCREEN_ROWS);
  localparam logic [ROW_W-1:0]  ROW_BOTTOM  = ROW_W'(SCREEN_ROWS - 1);

  // One command request
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              use_position;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] character;
    logic [BYTE_W-1:0] attribute;
  } item_t;

  // One result
  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
    logic [BYTE_W-1:0] read_char;
    logic [BYTE_W-1:0] read_attr;
    logic              bad_position;
  } result_t;

  // Engine handshake status towards the top level
  typedef struct packed {
    logic ready;
    logic done;
  } eng_status_t;

endpackage

[hw/rtl/tcw_cell_ram.sv]
// Screen cell store: one write port and one registered read port.
module tcw_cell_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [tcw_pkg::ADDR_W-1:0] waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [tcw_pkg::ADDR_W-1:0] raddr_i,
  output logic [tcw_pkg::CELL_W-1:0] rdata_o
);

  logic [tcw_pkg::CELL_W-1:0] mem_q [tcw_pkg::CELL_COUNT];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/tcw_engine.sv]
// Command sequencer with the shared cell address unit and the cursor.
module tcw_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  tcw_pkg::item_t             item_i,
  input  logic [tcw_pkg::BYTE_W-1:0] dflt_attr_i,
  input  logic                       out_free_i,
  output tcw_pkg::eng_status_t       status_o,
  output tcw_pkg::result_t           result_o,
  output logic                       ram_we_o,
  output logic [tcw_pkg::ADDR_W-1:0] ram_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0] ram_wdata_o,
  output logic                       ram_re_o,
  output logic [tcw_pkg::ADDR_W-1:0] ram_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0] ram_rdata_i
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_WRITE,
    S_READ,
    S_RDATA,
    S_SCROLL,
    S_BLANK,
    S_DONE
  } state_e;

  state_e                       state_q;
  tcw_pkg::item_t               item_q;
  logic [tcw_pkg::ROW_W-1:0]    cur_row_q;
  logic [tcw_pkg::COL_W-1:0]    cur_col_q;
  logic [tcw_pkg::ADDR_W-1:0]   addr_q;
  logic [tcw_pkg::ADDR_W-1:0]   idx_q;
  logic [tcw_pkg::ADDR_W-1:0]   wr_addr_q;
  logic                         pend_q;
  logic                         scrolled_q;
  logic                         bad_q;
  logic [tcw_pkg::BYTE_W-1:0]   rch_q;
  logic [tcw_pkg::BYTE_W-1:0]   rat_q;

  logic [tcw_pkg::ROW_W-1:0]    mul_row;
  logic [tcw_pkg::COL_W-1:0]    mul_col;
  logic [tcw_pkg::ADDR_W-1:0]   addr_d;
  logic                         on_screen;
  logic                         is_nl;
  logic [tcw_pkg::COL_W:0]      nc_sum;
  logic                         wrap;
  logic [tcw_pkg::ROW_W:0]      nr_sum;
  logic                         need_scroll;
  logic [tcw_pkg::BYTE_W-1:0]   attr_eff;
  logic [tcw_pkg::CELL_W-1:0]   blank_cell;

  // Shared address unit: target row times width plus column
  always_comb begin
    if (item_q.command == tcw_pkg::CMD_PUT && !item_q.use_position) begin
      mul_row = cur_row_q;
      mul_col = cur_col_q;
    end else begin
      mul_row = item_q.row;
      mul_col = item_q.col;
    end
    addr_d = tcw_pkg::ADDR_W'(mul_row) * tcw_pkg::COLS_A + tcw_pkg::ADDR_W'(mul_col);
  end

  // Position checks and next cursor of a put
  assign on_screen   = ({1'b0, item_q.row} < tcw_pkg::ROWS_R) &&
                       ({1'b0, item_q.col} < tcw_pkg::COLS_C);
  assign is_nl       = (item_q.character == tcw_pkg::NEWLINE_CODE);
  assign nc_sum      = {1'b0, mul_col} + 1'b1;
  assign wrap        = is_nl || (nc_sum == tcw_pkg::COLS_C);
  assign nr_sum      = {1'b0, mul_row} + {{tcw_pkg::ROW_W{1'b0}}, wrap};
  assign need_scroll = (nr_sum == tcw_pkg::ROWS_R);
  assign attr_eff    = (item_q.attribute == '0) ? dflt_attr_i : item_q.attribute;
  assign blank_cell  = {dflt_attr_i, tcw_pkg::SPACE_CODE};

  // Drive the cell store from the current step
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = blank_cell;
    ram_re_o    = 1'b0;
    ram_raddr_o = addr_q;
    case (state_q)
      S_INIT: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
      end
      S_WRITE: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = addr_q;
        ram_wdata_o = {attr_eff, item_q.character};
      end
      S_READ: begin
        ram_re_o = 1'b1;
      end
      S_SCROLL: begin
        ram_re_o    = (idx_q != tcw_pkg::MOVE_LAST_A);
        ram_raddr_o = idx_q + tcw_pkg::COLS_A;
        ram_we_o    = pend_q;
        ram_waddr_o = wr_addr_q;
        ram_wdata_o = ram_rdata_i;
      end
      S_BLANK: begin
        ram_we_o = 1'b1;
      end
      default: begin
        ram_we_o = 1'b0;
      end
    endcase
  end

  // Sequencer, cursor and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      addr_q     <= '0;
      idx_q      <= '0;
      wr_addr_q  <= '0;
      pend_q     <= 1'b0;
      scrolled_q <= 1'b0;
      bad_q      <= 1'b0;
      rch_q      <= '0;
      rat_q      <= '0;
    end else begin
      case (state_q)
        // Zero the store once after reset
        S_INIT: begin
          if (idx_q == tcw_pkg::CELL_LAST_A) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            scrolled_q <= 1'b0;
            bad_q      <= 1'b0;
            rch_q      <= '0;
            rat_q      <= '0;
            state_q    <= S_DECODE;
          end
        end
        S_DECODE: begin
          addr_q <= addr_d;
          idx_q  <= '0;
          pend_q <= 1'b0;
          case (item_q.command)
            tcw_pkg::CMD_PUT: begin
              if (item_q.use_position && !on_screen) begin
                bad_q   <= 1'b1;
                state_q <= S_DONE;
              end else begin
                if (need_scroll) begin
                  cur_row_q  <= tcw_pkg::ROW_BOTTOM;
                  cur_col_q  <= '0;
                  scrolled_q <= 1'b1;
                end else begin
                  cur_row_q <= nr_sum[tcw_pkg::ROW_W-1:0];
                  cur_col_q <= wrap ? '0 : nc_sum[tcw_pkg::COL_W-1:0];
                end
                if (!is_nl) begin
                  state_q <= S_WRITE;
                end else if (need_scroll) begin
                  state_q <= S_SCROLL;
                end else begin
                  state_q <= S_DONE;
                end
              end
            end
            tcw_pkg::CMD_SETC: begin
              if (on_screen) begin
                cur_row_q <= item_q.row;
                cur_col_q <= item_q.col;
              end else begin
                bad_q <= 1'b1;
              end
              state_q <= S_DONE;
            end
            tcw_pkg::CMD_CLEAR: begin
              cur_row_q <= '0;
              cur_col_q <= '0;
              state_q   <= S_BLANK;
            end
            default: begin
              if (on_screen) begin
                state_q <= S_READ;
              end else begin
                bad_q   <= 1'b1;
                state_q <= S_DONE;
              end
            end
          endcase
        end
        S_WRITE: begin
          state_q <= scrolled_q ? S_SCROLL : S_DONE;
        end
        S_READ: begin
          state_q <= S_RDATA;
        end
        S_RDATA: begin
          rch_q   <= ram_rdata_i[tcw_pkg::BYTE_W-1:0];
          rat_q   <= ram_rdata_i[tcw_pkg::CELL_W-1:tcw_pkg::BYTE_W];
          state_q <= S_DONE;
        end
        // Move each row up: read one row ahead, write the cell read last cycle
        S_SCROLL: begin
          wr_addr_q <= idx_q;
          if (idx_q == tcw_pkg::MOVE_LAST_A) begin
            pend_q  <= 1'b0;
            state_q <= S_BLANK;
          end else begin
            pend_q <= 1'b1;
            idx_q  <= idx_q + 1'b1;
          end
        end
        // Blank from idx_q to the last cell
        S_BLANK: begin
          if (idx_q == tcw_pkg::CELL_LAST_A) begin
            state_q <= S_DONE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        // Hold until the output register is free
        S_DONE: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      item_q <= item_i;
    end
  end

  assign status_o.ready = (state_q == S_IDLE);
  assign status_o.done  = (state_q == S_DONE);

  assign result_o.cursor_row   = cur_row_q;
  assign result_o.cursor_col   = cur_col_q;
  assign result_o.scrolled     = scrolled_q;
  assign result_o.read_char    = rch_q;
  assign result_o.read_attr    = rat_q;
  assign result_o.bad_position = bad_q;

endmodule

[hw/rtl/text_console_writer_top.sv]
// Top level of the text console writer: stream ports, register and output stage.
//
// Character-cell console of 80 columns by 25 rows with a cursor.
// Requests arrive on the s_axis channel: tuser carries the command and the
// positioned-put flag, tdata the row, column, character and attribute.
// Every request gives exactly one result on the m_axis channel, holding
// the cursor after the step, the scroll flag, a read cell and the
// off-screen flag.
// One request is worked on at a time; s_axis_tready is low meanwhile.
// A put of a character steps through decode, write and done; a newline with no
// scroll, a set cursor or an off-screen request through decode and done; a read
// through decode, read, read data and done; a put that scrolls adds scroll and
// blank. s_axis_tready rises again as the result enters the output register.
// The sequencer steps one cell a cycle through the cell store: a clear blanks
// 2000 cells; a scroll moves 1920 cells up a row and blanks the bottom 80. After
// reset a clearing pass zeroes all 2000 cells; s_axis_tready stays low during it.
// The default attribute register resets to 15 and is written through cfg_we_i /
// cfg_wdata_i; the user must write it only while the block is idle (unenforced).
// A result waits in the output register while m_axis_tready is low; the
// next request is still taken, and its result waits until the stage frees.
module text_console_writer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: row[4:0], col[11:5], character[19:12], attribute[27:20], zero fill
  input  logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // tuser: command[1:0], use_position[2]
  input  logic [tcw_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: cursor_row[4:0], cursor_col[11:5], scrolled[12], read_char[20:13],
  //        read_attr[28:21], bad_position[29], zero fill
  output logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::BYTE_W-1:0]    cfg_wdata_i
);

  localparam int RES_W = $bits(tcw_pkg::result_t);

  tcw_pkg::item_t               item;
  tcw_pkg::result_t             result;
  tcw_pkg::eng_status_t         status;
  logic [tcw_pkg::BYTE_W-1:0]   dflt_attr_q;
  logic                         out_free;
  logic                         ram_we;
  logic [tcw_pkg::ADDR_W-1:0]   ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [tcw_pkg::ADDR_W-1:0]   ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]   ram_rdata;
  logic [tcw_pkg::M_TDATA_W-1:0] m_tdata_d;

  // Unpack the request
  assign item.command      = s_axis_tuser[1:0];
  assign item.use_position = s_axis_tuser[2];
  assign item.row          = s_axis_tdata[4:0];
  assign item.col          = s_axis_tdata[11:5];
  assign item.character    = s_axis_tdata[19:12];
  assign item.attribute    = s_axis_tdata[27:20];

  assign s_axis_tready = status.ready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Default attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_attr_q <= tcw_pkg::DFLT_ATTR_RST;
    end else if (cfg_we_i) begin
      dflt_attr_q <= cfg_wdata_i;
    end
  end

  // Pack the result, lowest field first
  assign m_tdata_d = {{(tcw_pkg::M_TDATA_W - RES_W){1'b0}},
                      result.bad_position, result.read_attr, result.read_char,
                      result.scrolled, result.cursor_col, result.cursor_row};

  // Output register: load on done, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (status.done && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status.done && out_free) begin
      m_axis_tdata <= m_tdata_d;
    end
  end

  tcw_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid),
    .item_i      (item),
    .dflt_attr_i (dflt_attr_q),
    .out_free_i  (out_free),
    .status_o    (status),
    .result_o    (result),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  tcw_cell_ram u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[hw/rtl/tcw_checker.sv]
// Port checker of the text console writer and its bind to the top level.
module tcw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready
);

  // One request at a time: ready drops after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Cursor stays on screen
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:5] < 7'(tcw_pkg::SCREEN_COLS)) &&
                      (m_axis_tdata[4:0] < 5'(tcw_pkg::SCREEN_ROWS)))
    else $error("cursor off screen");

  // An off-screen request reads nothing and scrolls nothing
  a_bad_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[29] |-> m_axis_tdata[28:12] == '0)
    else $error("off-screen request gave data");

  // A scroll leaves the cursor at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |->
      m_axis_tdata[11:5] == '0 && m_axis_tdata[4:0] == tcw_pkg::ROW_BOTTOM)
    else $error("scroll left cursor off bottom row start");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

[dv/text_console_writer_top_tb.sv]
// Self-checking stream testbench for the text console writer top level.
`timescale 1ns / 100ps

module text_console_writer_top_tb;

  // Run shape and limits
  localparam int PHASE_ITEMS  = 270;
  localparam int MAX_IDLE     = 3;
  localparam int SLOW_CYCLES  = 2010;
  localparam int DRAIN_CYCLES = 2100;
  localparam int ITEM_BOUND   = 1500;
  localparam int CYCLE_LIMIT  = ITEM_BOUND * (SLOW_CYCLES + 2 * MAX_IDLE + 4) * 3
                                + 8 * DRAIN_CYCLES + tcw_pkg::CELL_COUNT + 100;
  localparam int unsigned NL_CHAR = 32'(tcw_pkg::NEWLINE_CODE);

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [tcw_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [tcw_pkg::BYTE_W-1:0]    cfg_wdata_i = tcw_pkg::DFLT_ATTR_RST;

  // Console model state
  logic [tcw_pkg::CELL_W-1:0] screen_mem [tcw_pkg::CELL_COUNT];
  int unsigned                model_row;
  int unsigned                model_col;
  logic [tcw_pkg::BYTE_W-1:0] model_attr;

  // Pending requests and expected console results
  tcw_pkg::item_t   cmd_req_q [$];
  tcw_pkg::result_t screen_result_q [$];
  tcw_pkg::item_t   live_req;

  int unsigned pushed_count = 0;
  int unsigned taken_count  = 0;
  int unsigned err_count    = 0;
  int unsigned cycle_count  = 0;
  bit          req_taken = 1'b0;
  bit          res_taken = 1'b0;
  int          tx_gap = 0;
  int          tx_streak = 0;
  bit          tx_calm = 1'b0;
  int          rx_stall = 0;
  int          rx_streak = 0;
  bit          rx_calm = 1'b0;

  text_console_writer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Print one mismatch line and count it
  task automatic flag_mismatch(string what, int unsigned want, int unsigned seen);
    $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, seen);
    err_count++;
  endtask

  // Idle cycles for one request; calm stretches run with no idling at all
  function automatic int draw_wait(inout int streak, inout bit calm);
    if (streak == 0) begin
      calm   = ($urandom_range(0, 3) == 0);
      streak = $urandom_range(5, 40);
    end
    streak--;
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Advance the console model by one request and return its result
  function automatic tcw_pkg::result_t console_step(tcw_pkg::item_t req);
    tcw_pkg::result_t           res;
    int unsigned                tr;
    int unsigned                tc;
    bit                         on_screen;
    logic [tcw_pkg::BYTE_W-1:0] attr;
    res       = '0;
    on_screen = (32'(req.row) < tcw_pkg::SCREEN_ROWS) &&
                (32'(req.col) < tcw_pkg::SCREEN_COLS);
    case (req.command)
      tcw_pkg::CMD_PUT: begin
        tr = model_row;
        tc = model_col;
        if (req.use_position) begin
          tr = 32'(req.row);
          tc = 32'(req.col);
        end
        if (req.use_position && !on_screen) begin
          res.bad_position = 1'b1;
        end else begin
          if (req.character == tcw_pkg::NEWLINE_CODE) begin
            tr = tr + 1;
            tc = 0;
          end else begin
            attr = (req.attribute == '0) ? model_attr : req.attribute;
            screen_mem[tr * tcw_pkg::SCREEN_COLS + tc] = {attr, req.character};
            tc = tc + 1;
            if (tc >= tcw_pkg::SCREEN_COLS) begin
              tc = 0;
              tr = tr + 1;
            end
          end
          // Scroll up one row past the bottom and blank the new last row
          if (tr >= tcw_pkg::SCREEN_ROWS) begin
            for (int i = 0; i < tcw_pkg::MOVE_COUNT; i++)
              screen_mem[i] = screen_mem[i + tcw_pkg::SCREEN_COLS];
            for (int i = tcw_pkg::MOVE_COUNT; i < tcw_pkg::CELL_COUNT; i++)
              screen_mem[i] = {model_attr, tcw_pkg::SPACE_CODE};
            tr = tcw_pkg::SCREEN_ROWS - 1;
            tc = 0;
            res.scrolled = 1'b1;
          end
          model_row = tr;
          model_col = tc;
        end
      end
      tcw_pkg::CMD_SETC: begin
        if (on_screen) begin
          model_row = 32'(req.row);
          model_col = 32'(req.col);
        end else begin
          res.bad_position = 1'b1;
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        for (int i = 0; i < tcw_pkg::CELL_COUNT; i++)
          screen_mem[i] = {model_attr, tcw_pkg::SPACE_CODE};
        model_row = 0;
        model_col = 0;
      end
      default: begin
        if (on_screen) begin
          {res.read_attr, res.read_char} =
            screen_mem[32'(req.row) * tcw_pkg::SCREEN_COLS + 32'(req.col)];
        end else begin
          res.bad_position = 1'b1;
        end
      end
    endcase
    res.cursor_row = model_row[tcw_pkg::ROW_W-1:0];
    res.cursor_col = model_col[tcw_pkg::COL_W-1:0];
    return res;
  endfunction

  function automatic tcw_pkg::item_t make_req(logic [tcw_pkg::CMD_W-1:0] cmd, logic use_pos,
                                              int unsigned row, int unsigned col,
                                              int unsigned ch, int unsigned attr);
    tcw_pkg::item_t req;
    req.command      = cmd;
    req.use_position = use_pos;
    req.row          = row[tcw_pkg::ROW_W-1:0];
    req.col          = col[tcw_pkg::COL_W-1:0];
    req.character    = ch[tcw_pkg::BYTE_W-1:0];
    req.attribute    = attr[tcw_pkg::BYTE_W-1:0];
    return req;
  endfunction

  task automatic push_req(tcw_pkg::item_t req);
    cmd_req_q.push_back(req);
    pushed_count++;
  endtask

  // Hold until every request is taken and every result is back, then settle
  task automatic wait_drained(int settle);
    while (cmd_req_q.size() != 0 || taken_count != pushed_count ||
           screen_result_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write the default attribute while the block is idle
  task automatic set_default_attr(logic [tcw_pkg::BYTE_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    model_attr  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Random requests: mostly single commands, some short lines of text read back
  task automatic run_random_phase(int count);
    int          made;
    int unsigned pick;
    int unsigned row;
    int unsigned col;
    int unsigned ch;
    int unsigned len;
    logic [tcw_pkg::CMD_W-1:0] cmd;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        row = $urandom_range(0, 1) ? $urandom_range(22, 24) : $urandom_range(0, 24);
        col = $urandom_range(0, 1) ? $urandom_range(66, 79) : $urandom_range(0, 79);
        len = $urandom_range(2, 12);
        push_req(make_req(tcw_pkg::CMD_SETC, 1'($urandom_range(0, 1)), row, col,
                          $urandom_range(0, 255), $urandom_range(0, 255)));
        for (int i = 0; i < len; i++) begin
          ch = $urandom_range(0, 255);
          if (ch == NL_CHAR) ch = 32'h41;
          push_req(make_req(tcw_pkg::CMD_PUT, 1'b0, $urandom_range(0, 31),
                            $urandom_range(0, 127), ch,
                            $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 255)));
        end
        if ($urandom_range(0, 1)) begin
          push_req(make_req(tcw_pkg::CMD_PUT, 1'b0, 0, 0, NL_CHAR, $urandom_range(0, 255)));
          len++;
        end
        push_req(make_req(tcw_pkg::CMD_READ, 1'b0, row, $urandom_range(0, 79), 0, 0));
        push_req(make_req(tcw_pkg::CMD_READ, 1'b0, row > 0 ? row - 1 : row,
                          $urandom_range(0, 79), 0, 0));
        made += len + 3;
      end else begin
        pick = $urandom_range(0, 99);
        cmd  = (pick < 50) ? tcw_pkg::CMD_PUT : (pick < 65) ? tcw_pkg::CMD_SETC
             : (pick < 67) ? tcw_pkg::CMD_CLEAR : tcw_pkg::CMD_READ;
        row  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 24);
        col  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 79);
        ch   = ($urandom_range(0, 9) == 0) ? NL_CHAR : $urandom_range(0, 255);
        push_req(make_req(cmd, $urandom_range(0, 9) < 3, row, col, ch,
                          $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 255)));
        made++;
      end
    end
  endtask

  // Driver: take requests at the rising edge, present the next one at the falling edge
  always begin
    @(posedge clk_i);
    req_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (req_taken) begin
      screen_result_q.push_back(console_step(live_req));
      taken_count++;
    end
    @(negedge clk_i);
    if (rst_ni && (!s_axis_tvalid || req_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid = 1'b0;
      end else if (cmd_req_q.size() > 0) begin
        live_req      = cmd_req_q.pop_front();
        s_axis_tdata  = {4'b0000, live_req.attribute, live_req.character,
                         live_req.col, live_req.row};
        s_axis_tuser  = {live_req.use_position, live_req.command};
        s_axis_tvalid = 1'b1;
        tx_gap        = draw_wait(tx_streak, tx_calm);
      end else begin
        s_axis_tvalid = 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation, stall at random
  always begin
    tcw_pkg::result_t want;
    @(posedge clk_i);
    res_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (res_taken) begin
      if (screen_result_q.size() == 0) begin
        flag_mismatch("unexpected result", 0, m_axis_tdata);
      end else begin
        want = screen_result_q.pop_front();
        if (m_axis_tdata[4:0] != want.cursor_row)
          flag_mismatch("cursor_row", 32'(want.cursor_row), 32'(m_axis_tdata[4:0]));
        if (m_axis_tdata[11:5] != want.cursor_col)
          flag_mismatch("cursor_col", 32'(want.cursor_col), 32'(m_axis_tdata[11:5]));
        if (m_axis_tdata[12] != want.scrolled)
          flag_mismatch("scrolled", 32'(want.scrolled), 32'(m_axis_tdata[12]));
        if (m_axis_tdata[20:13] != want.read_char)
          flag_mismatch("read_char", 32'(want.read_char), 32'(m_axis_tdata[20:13]));
        if (m_axis_tdata[28:21] != want.read_attr)
          flag_mismatch("read_attr", 32'(want.read_attr), 32'(m_axis_tdata[28:21]));
        if (m_axis_tdata[29] != want.bad_position)
          flag_mismatch("bad_position", 32'(want.bad_position), 32'(m_axis_tdata[29]));
      end
    end
    @(negedge clk_i);
    if (res_taken) rx_stall = draw_wait(rx_streak, rx_calm);
    if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** text_console_writer_top: FAILED **");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) screen_mem[i] = '0;
    model_row  = 0;
    model_col  = 0;
    model_attr = tcw_pkg::DFLT_ATTR_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: fresh cells, field extremes, wrap and scroll, off-screen, clear
    push_req(make_req(tcw_pkg::CMD_READ, 1'b0, 0, 0, 0, 0));
    push_req(make_req(tcw_pkg::CMD_READ, 1'b1, 24, 79, 255, 255));
    push_req(make_req(tcw_pkg::CMD_PUT, 1'b0, 0, 0, 32'h41, 0));
    push_req(make_req(tcw_pkg::CMD_PUT, 1'b0, 31, 127, 255, 255));
    push_req(make_req(tcw_pkg::CMD_PUT, 1'b1, 24, 79, 0, 32'h81));
    push_req(make_req(tcw_pkg::CMD_READ, 1'b0, 23, 79, 0, 0));
    push_req(make_req(tcw_pkg::CMD_READ, 1'b0, 24, 5, 0, 0));
    push_req(make_req(tcw_pkg::CMD_PUT, 1'b0, 0, 0, NL_CHAR, 32'h22));
    push_req(make_req(tcw_pkg::CMD_SETC, 1'b0, 12, 40, 32'h5A, 32'hC3));
    push_req(make_req(tcw_pkg::CMD_PUT, 1'b1, 3, 7, NL_CHAR, 0));
    push_req(make_req(tcw_pkg::CMD_SETC, 1'b1, 25, 0, 0, 0));
    push_req(make_req(tcw_pkg::CMD_SETC, 1'b0, 0, 80, 0, 0));
    push_req(make_req(tcw_pkg::CMD_PUT, 1'b1, 31, 127, 32'h42, 32'h11));
    push_req(make_req(tcw_pkg::CMD_READ, 1'b0, 31, 0, 0, 0));
    push_req(make_req(tcw_pkg::CMD_READ, 1'b0, 24, 80, 0, 0));
    push_req(make_req(tcw_pkg::CMD_SETC, 1'b0, 24, 79, 0, 0));
    push_req(make_req(tcw_pkg::CMD_PUT, 1'b0, 0, 0, 32'h5A, 32'h70));
    push_req(make_req(tcw_pkg::CMD_READ, 1'b0, 23, 79, 0, 0));
    push_req(make_req(tcw_pkg::CMD_CLEAR, 1'b1, 31, 127, 255, 255));
    push_req(make_req(tcw_pkg::CMD_READ, 1'b0, 10, 10, 0, 0));
    push_req(make_req(tcw_pkg::CMD_PUT, 1'b0, 31, 127, 32'h78, 0));
    push_req(make_req(tcw_pkg::CMD_PUT, 1'b0, 0, 0, NL_CHAR, 0));
    push_req(make_req(tcw_pkg::CMD_READ, 1'b0, 0, 0, 0, 0));
    push_req(make_req(tcw_pkg::CMD_READ, 1'b0, 1, 0, 0, 0));
    wait_drained(8);

    // Random phases over several default attributes, extremes first
    set_default_attr(8'h00);
    run_random_phase(PHASE_ITEMS);
    wait_drained(8);
    set_default_attr(8'hFF);
    run_random_phase(PHASE_ITEMS);
    for (int p = 0; p < 3; p++) begin
      wait_drained(8);
      set_default_attr(8'($urandom_range(1, 254)));
      run_random_phase(PHASE_ITEMS);
    end

    // Drain, then allow for a late stray result
    wait_drained(DRAIN_CYCLES);
    if (screen_result_q.size() != 0)
      flag_mismatch("results never received", 0, 32'(screen_result_q.size()));
    if (err_count == 0) begin
      $display("** text_console_writer_top: PASSED **");
    end else begin
      $display("** text_console_writer_top: FAILED **");
    end
    $finish;
  end

endmodule
